// File: design/tcw_pkg.sv
// shared types and constants of the text console writer
package tcw_pkg;

   // store geometry, row stride is MAX_COLS
   localparam int MAX_COLS = 80;
   localparam int MAX_ROWS = 25;
   localparam int CELLS    = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W   = $clog2(CELLS);

   // special character codes
   localparam logic [7:0] TAB_CODE     = 8'd9;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE   = 8'd32;

   // request kinds on req_tuser
   localparam logic [1:0] KIND_CHAR  = 2'd0;
   localparam logic [1:0] KIND_MOVE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // register indexes on the csr port
   localparam logic [2:0] CSR_COLS       = 3'd0;
   localparam logic [2:0] CSR_ROWS       = 3'd1;
   localparam logic [2:0] CSR_SCROLL     = 3'd2;
   localparam logic [2:0] CSR_TEXT_ATTR  = 3'd3;
   localparam logic [2:0] CSR_CLEAR_ATTR = 3'd4;

   // classified operation
   typedef enum logic [2:0] {
      OP_TAB,
      OP_NEWLINE,
      OP_PRINT,
      OP_MOVE,
      OP_CLEAR,
      OP_READ
   } op_type;

   // one queued command, targets already clamped
   typedef struct packed {
      op_type     op;
      logic [7:0] code;
      logic [6:0] col;
      logic [4:0] row;
   } cmd_type;

   // effective configuration, clamped to legal ranges
   typedef struct packed {
      logic [6:0] cols;
      logic [4:0] rows;
      logic [4:0] lines;
      logic [7:0] text_attr;
      logic [7:0] clear_attr;
   } cfg_type;

endpackage

// File: design/tcw_front.sv
// front end: takes requests, classifies them and clamps targets
module tcw_front (
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        req_tuser,   // kind
   input  logic [23:0]       req_tdata,   // char_code, target_col, target_row, zero pad
   input  tcw_pkg::cfg_type  cfg,
   input  logic              q_ready,
   output logic              q_push,
   output tcw_pkg::cmd_type  q_cmd
);

   logic [7:0] code;
   logic [6:0] tcol;
   logic [4:0] trow;
   logic [6:0] col_max;
   logic [4:0] row_max;

   // unpack fields
   assign code    = req_tdata[7:0];
   assign tcol    = req_tdata[14:8];
   assign trow    = req_tdata[19:15];
   assign col_max = cfg.cols - 7'd1;
   assign row_max = cfg.rows - 5'd1;

   // handshake straight onto the queue
   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

   // classify and clamp
   always_comb begin
      q_cmd.code = code;
      q_cmd.col  = (tcol > col_max) ? col_max : tcol;
      q_cmd.row  = (trow > row_max) ? row_max : trow;
      unique case (req_tuser)
         tcw_pkg::KIND_CHAR: begin
            if (code == tcw_pkg::TAB_CODE) begin
               q_cmd.op = tcw_pkg::OP_TAB;
            end else if (code == tcw_pkg::NEWLINE_CODE) begin
               q_cmd.op = tcw_pkg::OP_NEWLINE;
            end else begin
               q_cmd.op = tcw_pkg::OP_PRINT;
            end
         end
         tcw_pkg::KIND_MOVE:  q_cmd.op = tcw_pkg::OP_MOVE;
         tcw_pkg::KIND_CLEAR: q_cmd.op = tcw_pkg::OP_CLEAR;
         tcw_pkg::KIND_READ:  q_cmd.op = tcw_pkg::OP_READ;
         default:             q_cmd.op = tcw_pkg::OP_READ;
      endcase
   end

endmodule

// File: design/tcw_queue.sv
// two-entry command queue between front and back
module tcw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcw_pkg::cmd_type  push_cmd,
   output logic              ready,
   input  logic              pop,
   output logic              valid,
   output tcw_pkg::cmd_type  pop_cmd
);

   tcw_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign ready   = (count_ff != 2'd2);
   assign valid   = (count_ff != 2'd0);
   assign pop_cmd = entry_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/tcw_back.sv
// back end: cursor, cell store, clear and scroll sweeps, response register
module tcw_back (
   input  logic              clock,
   input  logic              reset,
   input  tcw_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  tcw_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata   // cursor_col, cursor_row, cell_char, cell_attr,
                                         // scrolled, zero pad
);

   localparam int AW = tcw_pkg::ADDR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NL,
      ST_SCROLL,
      ST_SCROLL_TAIL,
      ST_WRITE,
      ST_CLEAR,
      ST_READ,
      ST_RESP
   } state_type;

   function automatic logic [AW-1:0] cell_addr(input logic [4:0] row, input logic [6:0] col);
      cell_addr = AW'(row) * AW'(tcw_pkg::MAX_COLS) + AW'(col);
   endfunction

   state_type        state_ff, state_in;
   tcw_pkg::cmd_type cmd_ff, cmd_in;
   logic [6:0]       x_ff, x_in;
   logic [4:0]       y_ff, y_in;
   logic             ret_write_ff, ret_write_in;
   logic             scr_ff, scr_in;
   logic [4:0]       sw_row_ff, sw_row_in;
   logic [6:0]       sw_col_ff, sw_col_in;
   logic [AW-1:0]    dst_base_ff, dst_base_in;
   logic [AW-1:0]    src_base_ff, src_base_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             pend_blank_ff, pend_blank_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic [15:0]      rdata_ff;

   logic [15:0]      mem [tcw_pkg::CELLS];
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [15:0]      mem_wdata;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;

   logic             rsp_free;
   logic [4:0]       y_inc;
   logic [6:0]       x_inc;
   logic [7:0]       tab_sum;
   logic [7:0]       tab_col;
   logic [4:0]       keep_rows;
   logic [AW-1:0]    lines_base;
   logic             sweep_row_end;
   logic             sweep_last;
   logic [7:0]       out_char;
   logic [7:0]       out_attr;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // cursor arithmetic
   assign y_inc      = y_ff + 5'd1;
   assign x_inc      = x_ff + 7'd1;
   assign tab_sum    = {1'b0, x_ff} + 8'd8;
   assign tab_col    = {tab_sum[7:3], 3'b000};
   assign keep_rows  = cfg.rows - cfg.lines;
   assign lines_base = AW'(cfg.lines) * AW'(tcw_pkg::MAX_COLS);

   // sweep position over the visible area
   assign sweep_row_end = (sw_col_ff == cfg.cols - 7'd1);
   assign sweep_last    = sweep_row_end && (sw_row_ff == cfg.rows - 5'd1);

   // read data only goes out for a read request
   assign out_char = (cmd_ff.op == tcw_pkg::OP_READ) ? rdata_ff[7:0]  : 8'd0;
   assign out_attr = (cmd_ff.op == tcw_pkg::OP_READ) ? rdata_ff[15:8] : 8'd0;

   // next state and store access
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      ret_write_in  = ret_write_ff;
      scr_in        = scr_ff;
      sw_row_in     = sw_row_ff;
      sw_col_in     = sw_col_ff;
      dst_base_in   = dst_base_ff;
      src_base_in   = src_base_ff;
      pend_valid_in = 1'b0;
      pend_blank_in = pend_blank_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      // scroll write lands in the cycle after its read
      if (pend_valid_ff) begin
         mem_we    = 1'b1;
         mem_waddr = pend_addr_ff;
         mem_wdata = pend_blank_ff ? {rdata_ff[15:8], tcw_pkg::SPACE_CODE} : rdata_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               scr_in = 1'b0;
               unique case (q_cmd.op)
                  tcw_pkg::OP_TAB: begin
                     x_in     = ({1'b0, cfg.cols} < tab_col) ? cfg.cols : tab_col[6:0];
                     state_in = ST_RESP;
                  end
                  tcw_pkg::OP_NEWLINE: begin
                     ret_write_in = 1'b0;
                     state_in     = ST_NL;
                  end
                  tcw_pkg::OP_PRINT: begin
                     if (x_ff >= cfg.cols) begin
                        ret_write_in = 1'b1;
                        state_in     = ST_NL;
                     end else begin
                        state_in = ST_WRITE;
                     end
                  end
                  tcw_pkg::OP_MOVE: begin
                     x_in     = q_cmd.col;
                     y_in     = q_cmd.row;
                     state_in = ST_RESP;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     sw_row_in   = '0;
                     sw_col_in   = '0;
                     dst_base_in = '0;
                     state_in    = ST_CLEAR;
                  end
                  tcw_pkg::OP_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // new line, scroll when it runs past the last row
         ST_NL: begin
            x_in = '0;
            if (y_inc >= cfg.rows) begin
               scr_in      = 1'b1;
               sw_row_in   = '0;
               sw_col_in   = '0;
               dst_base_in = '0;
               src_base_in = lines_base;
               state_in    = ST_SCROLL;
            end else begin
               y_in     = y_inc;
               state_in = ret_write_ff ? ST_WRITE : ST_RESP;
            end
         end

         // one cell a cycle: copy from below, or blank the character
         ST_SCROLL: begin
            rd_en         = 1'b1;
            pend_valid_in = 1'b1;
            pend_addr_in  = dst_base_ff + AW'(sw_col_ff);
            if (sw_row_ff < keep_rows) begin
               rd_addr       = src_base_ff + AW'(sw_col_ff);
               pend_blank_in = 1'b0;
            end else begin
               rd_addr       = dst_base_ff + AW'(sw_col_ff);
               pend_blank_in = 1'b1;
            end
            if (sweep_row_end) begin
               sw_col_in   = '0;
               sw_row_in   = sw_row_ff + 5'd1;
               dst_base_in = dst_base_ff + AW'(tcw_pkg::MAX_COLS);
               src_base_in = src_base_ff + AW'(tcw_pkg::MAX_COLS);
            end else begin
               sw_col_in = sw_col_ff + 7'd1;
            end
            if (sweep_last) begin
               state_in = ST_SCROLL_TAIL;
            end
         end

         // last scroll write drains here
         ST_SCROLL_TAIL: begin
            y_in     = keep_rows;
            state_in = ret_write_ff ? ST_WRITE : ST_RESP;
         end

         // print at the cursor and advance
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(y_ff, x_ff);
            mem_wdata = {cfg.text_attr, cmd_ff.code};
            x_in      = x_inc;
            if (x_inc >= cfg.cols) begin
               ret_write_in = 1'b0;
               state_in     = ST_NL;
            end else begin
               state_in = ST_RESP;
            end
         end

         // fill the visible area, one cell a cycle
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = dst_base_ff + AW'(sw_col_ff);
            mem_wdata = {cfg.clear_attr, tcw_pkg::SPACE_CODE};
            if (sweep_row_end) begin
               sw_col_in   = '0;
               sw_row_in   = sw_row_ff + 5'd1;
               dst_base_in = dst_base_ff + AW'(tcw_pkg::MAX_COLS);
            end else begin
               sw_col_in = sw_col_ff + 7'd1;
            end
            if (sweep_last) begin
               x_in     = '0;
               y_in     = '0;
               state_in = ST_RESP;
            end
         end

         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = cell_addr(cmd_ff.row, cmd_ff.col);
            state_in = ST_RESP;
         end

         // hand the result to the output register
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, scr_ff, out_attr, out_char, y_ff, x_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_ff          <= '0;
         y_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      ret_write_ff  <= ret_write_in;
      scr_ff        <= scr_in;
      sw_row_ff     <= sw_row_in;
      sw_col_ff     <= sw_col_in;
      dst_base_ff   <= dst_base_in;
      src_base_ff   <= src_base_in;
      pend_blank_ff <= pend_blank_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // cell store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

endmodule

// File: design/text_console_writer.sv
// top level of the text console writer: csr block, front, queue and back
//
// Requests come in on req_* (kind on req_tuser, char_code, target_col and
// target_row on req_tdata); every request gives exactly one response on rsp_*
// carrying the cursor after the request, the cell read by a read request and
// a scrolled flag. Registers cols, rows, scroll_lines, text_attr and
// clear_attr sit on the csr_* port at byte addresses 0, 4, 8, 12 and 16.
// A two-entry queue sits between the front and the back end; the back end
// keeps the cursor and the cell store, a memory with one write and one
// registered read per cycle, and that store sets the pace.
// From the queue, move and tab go straight to the response state; a print,
// new line or read first passes its own state, and a wrapping one also new line.
// A clear sweeps each visible cell; a scroll copies or blanks each one, one
// cell per cycle, then drains its last write, and a character may scroll twice.
// The back end takes the next request the cycle after a response is registered.
// Reset brings back the register defaults, homes the cursor and empties the
// queue and the response register; the cell store is not cleared.
// When the receiver stalls, one response waits in the output register, the
// back end holds the next one, and req_tready drops once the queue is full.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // kind
   input  logic [23:0] req_tdata,   // char_code, target_col, target_row, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_col, cursor_row, cell_char, cell_attr,
                                    // scrolled, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [6:0]       cols_ff;
   logic [4:0]       rows_ff;
   logic [4:0]       scroll_ff;
   logic [7:0]       text_attr_ff;
   logic [7:0]       clear_attr_ff;
   logic             csr_write;
   logic [2:0]       csr_index;
   tcw_pkg::cfg_type cfg;
   logic [4:0]       lines_lo;
   logic             q_ready;
   logic             q_push;
   logic             q_valid;
   logic             q_pop;
   tcw_pkg::cmd_type push_cmd;
   tcw_pkg::cmd_type pop_cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff       <= 7'd80;
         rows_ff       <= 5'd25;
         scroll_ff     <= 5'd1;
         text_attr_ff  <= 8'd15;
         clear_attr_ff <= 8'd16;
      end else if (csr_write) begin
         unique case (csr_index)
            tcw_pkg::CSR_COLS:       cols_ff       <= csr_pwdata[6:0];
            tcw_pkg::CSR_ROWS:       rows_ff       <= csr_pwdata[4:0];
            tcw_pkg::CSR_SCROLL:     scroll_ff     <= csr_pwdata[4:0];
            tcw_pkg::CSR_TEXT_ATTR:  text_attr_ff  <= csr_pwdata[7:0];
            tcw_pkg::CSR_CLEAR_ATTR: clear_attr_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         tcw_pkg::CSR_COLS:       csr_prdata = {25'd0, cols_ff};
         tcw_pkg::CSR_ROWS:       csr_prdata = {27'd0, rows_ff};
         tcw_pkg::CSR_SCROLL:     csr_prdata = {27'd0, scroll_ff};
         tcw_pkg::CSR_TEXT_ATTR:  csr_prdata = {24'd0, text_attr_ff};
         tcw_pkg::CSR_CLEAR_ATTR: csr_prdata = {24'd0, clear_attr_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // clamp registers to the legal screen
   always_comb begin
      if (cols_ff == 7'd0) begin
         cfg.cols = 7'd1;
      end else if (cols_ff > 7'(tcw_pkg::MAX_COLS)) begin
         cfg.cols = 7'(tcw_pkg::MAX_COLS);
      end else begin
         cfg.cols = cols_ff;
      end
      if (rows_ff == 5'd0) begin
         cfg.rows = 5'd1;
      end else if (rows_ff > 5'(tcw_pkg::MAX_ROWS)) begin
         cfg.rows = 5'(tcw_pkg::MAX_ROWS);
      end else begin
         cfg.rows = rows_ff;
      end
      lines_lo       = (scroll_ff == 5'd0) ? 5'd1 : scroll_ff;
      cfg.lines      = (lines_lo > cfg.rows) ? cfg.rows : lines_lo;
      cfg.text_attr  = text_attr_ff;
      cfg.clear_attr = clear_attr_ff;
   end

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (pop_cmd)
   );

   tcw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_cmd      (pop_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clamped screen stays legal for any register contents
   a_cfg_range: assert property (@(posedge clock) disable iff (reset)
      (cfg.cols != 7'd0) && (cfg.cols <= 7'(tcw_pkg::MAX_COLS)) &&
      (cfg.lines != 5'd0) && (cfg.lines <= cfg.rows) &&
      (cfg.rows <= 5'(tcw_pkg::MAX_ROWS)))
      else $error("clamped screen geometry out of range");

   // reported cursor row stays in the store, its column at most MAX_COLS
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11:7] < 5'(tcw_pkg::MAX_ROWS)) &&
                     (rsp_tdata[6:0] <= 7'(tcw_pkg::MAX_COLS)))
      else $error("cursor out of store range");

   // reset empties the response register
   a_reset_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending after reset");

   // the queue is never popped while reset stays high
   a_reset_req: assert property (@(posedge clock)
      $past(reset) && reset |-> !(q_valid && q_pop))
      else $error("queue popped during reset");

endmodule
